// ===== design/bip_pkg.sv =====
// Shared constants, register codes and payload types of the ball intercept predictor.
package bip_pkg;

    // Field widths fixed by the interface
    localparam int IN_W      = 16;
    localparam int TIME_W    = 15;
    localparam int COORD_W   = 13;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // Divisor width: |vel_x| reaches 32768
    localparam int SPD_W  = 16;
    // Displacement product: 16-bit signed velocity times 15-bit time
    localparam int PROD_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME  = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_SPEED_RST = 15'd82;
    localparam logic [CFG_W-1:0] MAX_TIME_RST  = 15'd10240;

    // Fields carried alongside the time computation
    typedef struct packed {
        logic signed [IN_W-1:0] pos_y;
        logic signed [IN_W-1:0] pos_z;
        logic signed [IN_W-1:0] vel_y;
        logic signed [IN_W-1:0] vel_z;
    } side_t;

endpackage

// ===== design/bip_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and hands the beat on.
module bip_div_cell #(
    parameter int DIV_W = 29
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [DIV_W-1:0]            in_work,
    input  logic [bip_pkg::SPD_W-1:0]   in_rem,
    input  logic [bip_pkg::SPD_W-1:0]   in_speed,
    input  bip_pkg::side_t              in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [DIV_W-1:0]            out_work,
    output logic [bip_pkg::SPD_W-1:0]   out_rem,
    output logic [bip_pkg::SPD_W-1:0]   out_speed,
    output bip_pkg::side_t              out_side
);

    logic                        valid_reg;
    logic [DIV_W-1:0]            work_reg;
    logic [bip_pkg::SPD_W-1:0]   rem_reg;
    logic [bip_pkg::SPD_W-1:0]   speed_reg;
    bip_pkg::side_t              side_reg;

    logic [bip_pkg::SPD_W:0]     trial;
    logic [bip_pkg::SPD_W:0]     diff;
    logic                        fits;
    logic [DIV_W-1:0]            work_next;
    logic [bip_pkg::SPD_W-1:0]   rem_next;

    // Shift the next dividend bit into the remainder and try the subtract
    always_comb
    begin
        trial     = {in_rem, in_work[DIV_W-1]};
        diff      = trial - {1'b0, in_speed};
        fits      = (trial >= {1'b0, in_speed});
        rem_next  = fits ? diff[bip_pkg::SPD_W-1:0] : trial[bip_pkg::SPD_W-1:0];
        work_next = {in_work[DIV_W-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the beat until the next cell takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg  <= work_next;
            rem_reg   <= rem_next;
            speed_reg <= in_speed;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
    assign out_rem   = rem_reg;
    assign out_speed = speed_reg;
    assign out_side  = side_reg;

endmodule

// ===== design/bip_fold_cell.sv =====
// One mirror-reflection cell: folds y and z once back toward the unit interval.
module bip_fold_cell #(
    parameter int FRAC_BITS = 12,
    parameter int P_W       = 22
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [P_W-1:0]           in_p_y,
    input  logic signed [P_W-1:0]           in_p_z,
    input  logic [bip_pkg::TIME_W-1:0]      in_t,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [P_W-1:0]           out_p_y,
    output logic signed [P_W-1:0]           out_p_z,
    output logic [bip_pkg::TIME_W-1:0]      out_t
);

    localparam logic signed [P_W-1:0] ONE_Q = P_W'(1) << FRAC_BITS;
    localparam logic signed [P_W-1:0] TWO_Q = P_W'(1) << (FRAC_BITS + 1);

    logic                            valid_reg;
    logic signed [P_W-1:0]           p_y_reg;
    logic signed [P_W-1:0]           p_z_reg;
    logic [bip_pkg::TIME_W-1:0]      t_reg;

    logic signed [P_W-1:0]           p_y_next;
    logic signed [P_W-1:0]           p_z_next;

    // Reflect at 0 or at 1; a value already inside stays put
    always_comb
    begin
        if (in_p_y < 0)
            p_y_next = -in_p_y;
        else if (in_p_y > ONE_Q)
            p_y_next = TWO_Q - in_p_y;
        else
            p_y_next = in_p_y;

        if (in_p_z < 0)
            p_z_next = -in_p_z;
        else if (in_p_z > ONE_Q)
            p_z_next = TWO_Q - in_p_z;
        else
            p_z_next = in_p_z;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            p_y_reg <= p_y_next;
            p_z_reg <= p_z_next;
            t_reg   <= in_t;
        end
    end

    assign out_valid = valid_reg;
    assign out_p_y   = p_y_reg;
    assign out_p_z   = p_z_reg;
    assign out_t     = t_reg;

endmodule

// ===== design/ball_intercept_predictor.sv =====
// Top level: predicts time and y/z position where the ball crosses x = 1.
//
//  channel | signals                                  | beat
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, pos_*, vel_*         | one tracked ball state
//  out     | out_valid, out_ready, hit_time/_y/_z     | one intercept prediction
//  cfg     | cfg_we, cfg_index, cfg_data              | one register write, no wait
//
//  One beat enters per cycle unless a stall at the output has filled the pipeline;
//  the row of division cells holds one cell per quotient bit.
//  Every stage holds its own valid bit, so a stall at the output only backs up
//  stages that are occupied and bubbles are squeezed out.
//  Reset clears all valid bits and loads min_speed = 82 and max_time = 10240.
module ball_intercept_predictor #(
    parameter int FRAC_BITS       = 12,
    parameter int MAX_REFLECTIONS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bip_pkg::IN_W-1:0]     pos_x,
    input  logic signed [bip_pkg::IN_W-1:0]     pos_y,
    input  logic signed [bip_pkg::IN_W-1:0]     pos_z,
    input  logic signed [bip_pkg::IN_W-1:0]     vel_x,
    input  logic signed [bip_pkg::IN_W-1:0]     vel_y,
    input  logic signed [bip_pkg::IN_W-1:0]     vel_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bip_pkg::TIME_W-1:0]          hit_time,
    output logic [bip_pkg::COORD_W-1:0]         hit_y,
    output logic [bip_pkg::COORD_W-1:0]         hit_z,
    input  logic                                cfg_we,
    input  logic [bip_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bip_pkg::CFG_W-1:0]           cfg_data
);

    // Numerator 1.0 - pos_x, positive part, unsigned
    localparam int NUM_W  = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
    localparam int DIV_W  = NUM_W + FRAC_BITS;
    localparam int DISP_W = bip_pkg::PROD_W - FRAC_BITS;
    localparam int P_BASE = (DISP_W > FRAC_BITS + 1) ? DISP_W : FRAC_BITS + 1;
    localparam int P_W    = ((P_BASE > bip_pkg::IN_W) ? P_BASE : bip_pkg::IN_W) + 2;

    localparam logic signed [NUM_W:0] ONE_N = (NUM_W + 1)'(1) << FRAC_BITS;
    localparam logic signed [P_W-1:0] ONE_P = P_W'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bip_pkg::CFG_W-1:0] min_speed_reg;
    logic [bip_pkg::CFG_W-1:0] max_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= bip_pkg::MIN_SPEED_RST;
            max_time_reg  <= bip_pkg::MAX_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bip_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data;
                bip_pkg::REG_MAX_TIME:  max_time_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: numerator, dividend and floored divisor
    // ------------------------------------------------------------------
    logic                               s0_valid_reg;
    logic [DIV_W-1:0]                   s0_work_reg;
    logic [bip_pkg::SPD_W-1:0]          s0_speed_reg;
    bip_pkg::side_t                     s0_side_reg;
    logic                               s0_ready;

    logic signed [NUM_W:0]              num;
    logic [DIV_W-1:0]                   dividend;
    logic [bip_pkg::SPD_W-1:0]          abs_vx;
    logic [bip_pkg::SPD_W-1:0]          floor_spd;
    logic [bip_pkg::SPD_W-1:0]          speed;

    always_comb
    begin
        num = ONE_N - (NUM_W + 1)'(pos_x);
        // Ball at or past the plane divides zero
        if (num > 0)
            dividend = {num[NUM_W-1:0], {FRAC_BITS{1'b0}}};
        else
            dividend = '0;

        abs_vx    = vel_x[bip_pkg::IN_W-1] ? (~bip_pkg::SPD_W'(vel_x) + 1'b1)
                                           : bip_pkg::SPD_W'(vel_x);
        floor_spd = {1'b0, min_speed_reg};
        speed     = (abs_vx < floor_spd) ? floor_spd : abs_vx;
        if (speed == '0)
            speed = bip_pkg::SPD_W'(1);
    end

    logic                               dv_valid [0:DIV_W];
    logic                               dv_ready [0:DIV_W];
    logic [DIV_W-1:0]                   dv_work  [0:DIV_W];
    logic [bip_pkg::SPD_W-1:0]          dv_rem   [0:DIV_W];
    logic [bip_pkg::SPD_W-1:0]          dv_speed [0:DIV_W];
    bip_pkg::side_t                     dv_side  [0:DIV_W];

    assign s0_ready = !s0_valid_reg || dv_ready[0];
    assign in_ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_work_reg        <= dividend;
            s0_speed_reg       <= speed;
            s0_side_reg.pos_y  <= pos_y;
            s0_side_reg.pos_z  <= pos_z;
            s0_side_reg.vel_y  <= vel_y;
            s0_side_reg.vel_z  <= vel_z;
        end
    end

    // ------------------------------------------------------------------
    // Row of division cells, one quotient bit each
    // ------------------------------------------------------------------
    assign dv_valid[0] = s0_valid_reg;
    assign dv_work[0]  = s0_work_reg;
    assign dv_rem[0]   = '0;
    assign dv_speed[0] = s0_speed_reg;
    assign dv_side[0]  = s0_side_reg;

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_div
        bip_div_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_work   (dv_work[k]),
            .in_rem    (dv_rem[k]),
            .in_speed  (dv_speed[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_work  (dv_work[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_speed (dv_speed[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp the quotient to max_time
    // ------------------------------------------------------------------
    logic                               s1_valid_reg;
    logic [bip_pkg::TIME_W-1:0]         s1_t_reg;
    bip_pkg::side_t                     s1_side_reg;
    logic                               s1_ready;
    logic                               s1_in_fire;
    logic [bip_pkg::TIME_W-1:0]         t_clamped;

    logic                               s2_ready;

    assign t_clamped = (dv_work[DIV_W] > DIV_W'(max_time_reg))
                     ? max_time_reg : dv_work[DIV_W][bip_pkg::TIME_W-1:0];

    assign s1_ready        = !s1_valid_reg || s2_ready;
    assign dv_ready[DIV_W] = s1_ready;
    assign s1_in_fire      = s1_ready && dv_valid[DIV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= dv_valid[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_in_fire)
        begin
            s1_t_reg    <= t_clamped;
            s1_side_reg <= dv_side[DIV_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: velocity times time for y and z
    // ------------------------------------------------------------------
    logic                               s2_valid_reg;
    logic signed [bip_pkg::PROD_W-1:0]  s2_prod_y_reg;
    logic signed [bip_pkg::PROD_W-1:0]  s2_prod_z_reg;
    logic signed [bip_pkg::IN_W-1:0]    s2_pos_y_reg;
    logic signed [bip_pkg::IN_W-1:0]    s2_pos_z_reg;
    logic [bip_pkg::TIME_W-1:0]         s2_t_reg;

    logic signed [bip_pkg::IN_W-1:0]    t_signed;
    logic signed [bip_pkg::PROD_W-1:0]  mul_y;
    logic signed [bip_pkg::PROD_W-1:0]  mul_z;

    logic                               s3_ready;

    assign t_signed = $signed({1'b0, s1_t_reg});
    assign mul_y    = bip_pkg::PROD_W'(s1_side_reg.vel_y) * bip_pkg::PROD_W'(t_signed);
    assign mul_z    = bip_pkg::PROD_W'(s1_side_reg.vel_z) * bip_pkg::PROD_W'(t_signed);
    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_y_reg <= mul_y;
            s2_prod_z_reg <= mul_z;
            s2_pos_y_reg  <= s1_side_reg.pos_y;
            s2_pos_z_reg  <= s1_side_reg.pos_z;
            s2_t_reg      <= s1_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the product back, rounding toward zero, and add
    // ------------------------------------------------------------------
    logic                               s3_valid_reg;
    logic signed [P_W-1:0]              s3_p_y_reg;
    logic signed [P_W-1:0]              s3_p_z_reg;
    logic [bip_pkg::TIME_W-1:0]         s3_t_reg;

    logic [bip_pkg::PROD_W-1:0]         mag_y;
    logic [bip_pkg::PROD_W-1:0]         mag_z;
    logic signed [P_W-1:0]              disp_y;
    logic signed [P_W-1:0]              disp_z;
    logic signed [P_W-1:0]              p_y_sum;
    logic signed [P_W-1:0]              p_z_sum;

    logic                               fd_valid [0:MAX_REFLECTIONS];
    logic                               fd_ready [0:MAX_REFLECTIONS];
    logic signed [P_W-1:0]              fd_p_y   [0:MAX_REFLECTIONS];
    logic signed [P_W-1:0]              fd_p_z   [0:MAX_REFLECTIONS];
    logic [bip_pkg::TIME_W-1:0]         fd_t     [0:MAX_REFLECTIONS];

    always_comb
    begin
        mag_y   = s2_prod_y_reg[bip_pkg::PROD_W-1] ? (~s2_prod_y_reg + 1'b1) : s2_prod_y_reg;
        mag_z   = s2_prod_z_reg[bip_pkg::PROD_W-1] ? (~s2_prod_z_reg + 1'b1) : s2_prod_z_reg;
        disp_y  = $signed(P_W'(mag_y[bip_pkg::PROD_W-1:FRAC_BITS]));
        disp_z  = $signed(P_W'(mag_z[bip_pkg::PROD_W-1:FRAC_BITS]));
        p_y_sum = s2_prod_y_reg[bip_pkg::PROD_W-1] ? (P_W'(s2_pos_y_reg) - disp_y)
                                                   : (P_W'(s2_pos_y_reg) + disp_y);
        p_z_sum = s2_prod_z_reg[bip_pkg::PROD_W-1] ? (P_W'(s2_pos_z_reg) - disp_z)
                                                   : (P_W'(s2_pos_z_reg) + disp_z);
    end

    assign s3_ready = !s3_valid_reg || fd_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_p_y_reg <= p_y_sum;
            s3_p_z_reg <= p_z_sum;
            s3_t_reg   <= s2_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Row of reflection cells, one fold each
    // ------------------------------------------------------------------
    assign fd_valid[0] = s3_valid_reg;
    assign fd_p_y[0]   = s3_p_y_reg;
    assign fd_p_z[0]   = s3_p_z_reg;
    assign fd_t[0]     = s3_t_reg;

    for (genvar r = 0; r < MAX_REFLECTIONS; r++)
    begin : g_fold
        bip_fold_cell #(
            .FRAC_BITS (FRAC_BITS),
            .P_W       (P_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (fd_valid[r]),
            .in_ready  (fd_ready[r]),
            .in_p_y    (fd_p_y[r]),
            .in_p_z    (fd_p_z[r]),
            .in_t      (fd_t[r]),
            .out_valid (fd_valid[r+1]),
            .out_ready (fd_ready[r+1]),
            .out_p_y   (fd_p_y[r+1]),
            .out_p_z   (fd_p_z[r+1]),
            .out_t     (fd_t[r+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: clamp to [0, 1.0] and mask to field width
    // ------------------------------------------------------------------
    logic                               out_valid_reg;
    logic [bip_pkg::TIME_W-1:0]         hit_time_reg;
    logic [bip_pkg::COORD_W-1:0]        hit_y_reg;
    logic [bip_pkg::COORD_W-1:0]        hit_z_reg;
    logic                               out_slot_free;
    logic signed [P_W-1:0]              y_clamped;
    logic signed [P_W-1:0]              z_clamped;

    always_comb
    begin
        if (fd_p_y[MAX_REFLECTIONS] < 0)
            y_clamped = '0;
        else if (fd_p_y[MAX_REFLECTIONS] > ONE_P)
            y_clamped = ONE_P;
        else
            y_clamped = fd_p_y[MAX_REFLECTIONS];

        if (fd_p_z[MAX_REFLECTIONS] < 0)
            z_clamped = '0;
        else if (fd_p_z[MAX_REFLECTIONS] > ONE_P)
            z_clamped = ONE_P;
        else
            z_clamped = fd_p_z[MAX_REFLECTIONS];
    end

    assign out_slot_free             = !out_valid_reg || out_ready;
    assign fd_ready[MAX_REFLECTIONS] = out_slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_slot_free)
        begin
            out_valid_reg <= fd_valid[MAX_REFLECTIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_slot_free && fd_valid[MAX_REFLECTIONS])
        begin
            hit_time_reg <= fd_t[MAX_REFLECTIONS];
            hit_y_reg    <= y_clamped[bip_pkg::COORD_W-1:0];
            hit_z_reg    <= z_clamped[bip_pkg::COORD_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_time  = hit_time_reg;
    assign hit_y     = hit_y_reg;
    assign hit_z     = hit_z_reg;

`ifndef NO_ASSERTIONS
    // Hit time never exceeds the configured clamp
    a_time_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_time <= max_time_reg))
        else $error("hit_time above max_time");

    // Folded and clamped coordinates stay inside the field
    a_y_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (FRAC_BITS <= 12)) |-> (hit_y <= bip_pkg::COORD_W'(ONE_P)))
        else $error("hit_y outside field");

    a_z_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (FRAC_BITS <= 12)) |-> (hit_z <= bip_pkg::COORD_W'(ONE_P)))
        else $error("hit_z outside field");

    // A beat in the clamp stage was already limited to max_time
    a_stage_time: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_t_reg <= max_time_reg))
        else $error("clamp stage time above max_time");
`endif

endmodule
